@@ rtl/core/fca_pkg.sv @@
// Shared constants, codes and control types of the chain allocator.
package fca_pkg;

    localparam int NUM_BLOCKS    = 20;
    localparam int BLOCK_BYTES   = 128;
    localparam int FDB_RESET     = 3;
    localparam int IDX_W         = $clog2(NUM_BLOCKS);
    localparam int CNT_W         = $clog2(NUM_BLOCKS + 1);
    localparam int SCAN_MAX      = (NUM_BLOCKS > 31) ? NUM_BLOCKS : 31;
    localparam int SCAN_W        = $clog2(SCAN_MAX + 1);

    localparam logic [15:0] LINK_FREE = 16'h0000;
    localparam logic [15:0] LINK_END  = 16'hFFFF;

    typedef enum logic [1:0] {
        KIND_REWRITE = 2'd0,
        KIND_FREE    = 2'd1,
        KIND_NEXT    = 2'd2,
        KIND_FORMAT  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_NO_SPACE = 2'd1,
        STATUS_RANGE    = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_FREE_WALK,
        ST_ALLOC_SCAN,
        ST_ALLOC_END,
        ST_FORMAT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic walk_step;
        logic scan_start;
        logic scan_sel;
        logic scan_next;
        logic take;
        logic no_space;
        logic end_write;
        logic fmt_write;
        logic result_load;
    } cmd_t;

    typedef struct packed {
        kind_t kind;
        logic  free_bad;
        logic  walk_stop;
        logic  walk_last;
        logic  scan_out;
        logic  scan_free;
        logic  rem_zero;
        logic  fmt_last;
        logic  out_free;
    } sts_t;

endpackage

@@ rtl/core/fca_in_if.sv @@
// Request channel: operation words into the allocator.
interface fca_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [15:0] block;
    logic [15:0] byte_length;

    modport source (output valid, output kind, output block, output byte_length, input ready);
    modport sink   (input valid, input kind, input block, input byte_length, output ready);
endinterface

@@ rtl/core/fca_out_if.sv @@
// Response channel: result words out of the allocator.
interface fca_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [15:0] chain_head;
    logic [15:0] link_value;
    logic [4:0]  blocks_taken;

    modport source (output valid, output status, output chain_head, output link_value,
                    output blocks_taken, input ready);
    modport sink   (input valid, input status, input chain_head, input link_value,
                    input blocks_taken, output ready);
endinterface

@@ rtl/core/fca_ctrl.sv @@
// Controller state machine sequencing walk, scan and format passes.
module fca_ctrl (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  fca_pkg::sts_t sts,
    output fca_pkg::cmd_t cmd
);

    fca_pkg::state_t state_reg;
    fca_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fca_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            fca_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = fca_pkg::ST_DISPATCH;
                end
            end
            fca_pkg::ST_DISPATCH:
            begin
                unique case (sts.kind)
                    fca_pkg::KIND_REWRITE: state_next = fca_pkg::ST_FREE_WALK;
                    fca_pkg::KIND_FREE:
                        state_next = sts.free_bad ? fca_pkg::ST_DONE : fca_pkg::ST_FREE_WALK;
                    fca_pkg::KIND_NEXT:    state_next = fca_pkg::ST_DONE;
                    fca_pkg::KIND_FORMAT:  state_next = fca_pkg::ST_FORMAT;
                    default:               state_next = fca_pkg::ST_DONE;
                endcase
            end
            fca_pkg::ST_FREE_WALK:
            begin
                if (sts.walk_stop || sts.walk_last)
                begin
                    // the last live link is still cleared on the way out
                    cmd.walk_step = !sts.walk_stop;
                    if (sts.kind == fca_pkg::KIND_REWRITE)
                    begin
                        cmd.scan_start = 1'b1;
                        state_next     = fca_pkg::ST_ALLOC_SCAN;
                    end
                    else
                    begin
                        state_next = fca_pkg::ST_DONE;
                    end
                end
                else
                begin
                    cmd.walk_step = 1'b1;
                end
            end
            fca_pkg::ST_ALLOC_SCAN:
            begin
                cmd.scan_sel = 1'b1;
                if (sts.rem_zero)
                begin
                    state_next = fca_pkg::ST_ALLOC_END;
                end
                else if (sts.scan_out)
                begin
                    cmd.no_space = 1'b1;
                    state_next   = fca_pkg::ST_ALLOC_END;
                end
                else if (sts.scan_free)
                begin
                    cmd.take = 1'b1;
                end
                else
                begin
                    cmd.scan_next = 1'b1;
                end
            end
            fca_pkg::ST_ALLOC_END:
            begin
                cmd.end_write = 1'b1;
                state_next    = fca_pkg::ST_DONE;
            end
            fca_pkg::ST_FORMAT:
            begin
                cmd.fmt_write = 1'b1;
                if (sts.fmt_last)
                begin
                    state_next = fca_pkg::ST_DONE;
                end
            end
            fca_pkg::ST_DONE:
            begin
                // hold until the output register can take the word
                if (sts.out_free)
                begin
                    cmd.result_load = 1'b1;
                    state_next      = fca_pkg::ST_IDLE;
                end
            end
            default: state_next = fca_pkg::ST_IDLE;
        endcase
    end

endmodule

@@ rtl/core/fca_dp.sv @@
// Datapath: link table, walk and scan pointers, result register.
module fca_dp (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic [4:0]    cfg_wdata,
    input  logic [1:0]    in_kind,
    input  logic [15:0]   in_block,
    input  logic [15:0]   in_byte_length,
    input  fca_pkg::cmd_t cmd,
    output fca_pkg::sts_t sts,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [1:0]    out_status,
    output logic [15:0]   out_chain_head,
    output logic [15:0]   out_link_value,
    output logic [4:0]    out_blocks_taken
);

    localparam int SCAN_WL = fca_pkg::SCAN_W;
    localparam int IDX_WL  = fca_pkg::IDX_W;
    localparam int CNT_WL  = fca_pkg::CNT_W;
    localparam logic [SCAN_WL-1:0] NUM_S = SCAN_WL'(fca_pkg::NUM_BLOCKS);

    logic [15:0]             table_reg [fca_pkg::NUM_BLOCKS];
    logic [4:0]              fdb_reg;
    fca_pkg::kind_t          kind_reg;
    logic [15:0]             cur_reg;
    logic [IDX_WL-1:0]       steps_reg;
    logic [15:0]             rem_reg;
    logic [SCAN_WL-1:0]      scan_reg;
    logic [IDX_WL-1:0]       prev_reg;
    logic                    have_prev_reg;
    logic [15:0]             first_reg;
    logic [CNT_WL-1:0]       taken_reg;
    fca_pkg::status_t        status_reg;
    logic                    res_valid_reg;
    logic [1:0]              res_status_reg;
    logic [15:0]             res_first_reg;
    logic [15:0]             res_link_reg;
    logic [4:0]              res_taken_reg;

    logic [IDX_WL-1:0]       rd_idx;
    logic                    rd_ok;
    logic [15:0]             rd_data;
    logic                    cur_in_range;
    logic                    scan_in_range;
    logic                    wr_en;
    logic [IDX_WL-1:0]       wr_idx;
    logic [15:0]             wr_data;
    logic [SCAN_WL-1:0]      fdb_ext;
    fca_pkg::status_t        load_status;

    assign fdb_ext       = SCAN_WL'(fdb_reg);
    assign cur_in_range  = (cur_reg < 16'(fca_pkg::NUM_BLOCKS));
    assign scan_in_range = (scan_reg < NUM_S);

    // single read port, guarded so an out-of-range index reads as free
    assign rd_idx  = cmd.scan_sel ? scan_reg[IDX_WL-1:0] : cur_reg[IDX_WL-1:0];
    assign rd_ok   = cmd.scan_sel ? scan_in_range : cur_in_range;
    assign rd_data = rd_ok ? table_reg[rd_idx] : fca_pkg::LINK_FREE;

    always_comb
    begin
        load_status = fca_pkg::STATUS_OK;
        if (in_block >= 16'(fca_pkg::NUM_BLOCKS))
        begin
            if (in_kind == fca_pkg::KIND_NEXT)
            begin
                load_status = fca_pkg::STATUS_RANGE;
            end
            else if (in_kind == fca_pkg::KIND_FREE && in_block != fca_pkg::LINK_END)
            begin
                load_status = fca_pkg::STATUS_RANGE;
            end
        end
    end

    always_comb
    begin
        wr_en   = 1'b0;
        wr_idx  = cur_reg[IDX_WL-1:0];
        wr_data = fca_pkg::LINK_FREE;
        if (cmd.walk_step)
        begin
            wr_en = 1'b1;
        end
        else if (cmd.take && have_prev_reg)
        begin
            // link the previous block to the one just found
            wr_en   = 1'b1;
            wr_idx  = prev_reg;
            wr_data = 16'(scan_reg);
        end
        else if (cmd.end_write && have_prev_reg)
        begin
            wr_en   = 1'b1;
            wr_idx  = prev_reg;
            wr_data = fca_pkg::LINK_END;
        end
        else if (cmd.fmt_write)
        begin
            wr_en   = 1'b1;
            wr_idx  = scan_reg[IDX_WL-1:0];
            wr_data = (scan_reg < fdb_ext) ? fca_pkg::LINK_END : fca_pkg::LINK_FREE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < fca_pkg::NUM_BLOCKS; i++)
            begin
                table_reg[i] <= (i < fca_pkg::FDB_RESET) ? fca_pkg::LINK_END
                                                         : fca_pkg::LINK_FREE;
            end
        end
        else if (wr_en)
        begin
            table_reg[wr_idx] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fdb_reg       <= 5'(fca_pkg::FDB_RESET);
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                fdb_reg <= cfg_wdata;
            end
            if (cmd.result_load)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg      <= fca_pkg::kind_t'(in_kind);
            cur_reg       <= in_block;
            rem_reg       <= in_byte_length;
            steps_reg     <= '0;
            scan_reg      <= '0;
            have_prev_reg <= 1'b0;
            first_reg     <= fca_pkg::LINK_END;
            taken_reg     <= '0;
            status_reg    <= load_status;
        end
        else
        begin
            if (cmd.walk_step)
            begin
                cur_reg   <= rd_data;
                steps_reg <= steps_reg + 1'b1;
            end
            if (cmd.scan_start)
            begin
                scan_reg <= fdb_ext;
            end
            else if (cmd.scan_next || cmd.fmt_write)
            begin
                scan_reg <= scan_reg + 1'b1;
            end
            else if (cmd.take)
            begin
                scan_reg      <= scan_reg + 1'b1;
                prev_reg      <= scan_reg[IDX_WL-1:0];
                have_prev_reg <= 1'b1;
                taken_reg     <= taken_reg + 1'b1;
                rem_reg       <= (rem_reg > 16'(fca_pkg::BLOCK_BYTES))
                                 ? rem_reg - 16'(fca_pkg::BLOCK_BYTES) : 16'd0;
                if (!have_prev_reg)
                begin
                    first_reg <= 16'(scan_reg);
                end
            end
            if (cmd.no_space)
            begin
                status_reg <= fca_pkg::STATUS_NO_SPACE;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.result_load)
        begin
            res_status_reg <= status_reg;
            res_first_reg  <= first_reg;
            res_link_reg   <= (kind_reg == fca_pkg::KIND_NEXT && status_reg == fca_pkg::STATUS_OK)
                              ? rd_data : fca_pkg::LINK_FREE;
            res_taken_reg  <= 5'(taken_reg);
        end
    end

    always_comb
    begin
        sts.kind      = kind_reg;
        sts.free_bad  = (cur_reg != fca_pkg::LINK_END) && !cur_in_range;
        sts.walk_stop = (cur_reg == fca_pkg::LINK_FREE) || !cur_in_range;
        sts.walk_last = (rd_data == fca_pkg::LINK_END) ||
                        (steps_reg == IDX_WL'(fca_pkg::NUM_BLOCKS - 1));
        sts.scan_out  = !scan_in_range;
        sts.scan_free = (rd_data == fca_pkg::LINK_FREE);
        sts.rem_zero  = (rem_reg == 16'd0);
        sts.fmt_last  = (scan_reg == NUM_S - 1'b1);
        sts.out_free  = !res_valid_reg || out_ready;
    end

    assign out_valid        = res_valid_reg;
    assign out_status       = res_status_reg;
    assign out_chain_head   = res_first_reg;
    assign out_link_value   = res_link_reg;
    assign out_blocks_taken = res_taken_reg;

endmodule

@@ rtl/core/fat_chain_allocator_top.sv @@
// Top level of the file allocation table chain allocator.
//
// One request word in (req), one response word out (rsp), valid/ready on both.
// A request carries kind (rewrite, free, next, format), a block index and a
// byte length; the response carries status, first block of a new chain, the
// link read by next, and the number of blocks taken.
// One request is worked at a time. Next and out-of-range free go straight to
// the response; free walks the chain, rewrite walks the old chain and then
// scans for free entries (at most NUM_BLOCKS), and format writes every entry.
// The table's single read and write port serves one entry a cycle during walk,
// scan and format passes. A new request is taken as soon as the previous
// response sits in the output register.
// cfg_we/cfg_wdata set first_data_block; write it only while idle.
// Reset: table entries 0..2 read end, the rest free, first_data_block is 3,
// no response pending. A stalled rsp holds its word; the next response waits
// in the controller until the output register frees.
module fat_chain_allocator_top (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [4:0] cfg_wdata,
    fca_in_if.sink     req,
    fca_out_if.source  rsp
);

    fca_pkg::cmd_t cmd;
    fca_pkg::sts_t sts;

    fca_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    fca_dp u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata),
        .in_kind          (req.kind),
        .in_block         (req.block),
        .in_byte_length   (req.byte_length),
        .cmd              (cmd),
        .sts              (sts),
        .out_valid        (rsp.valid),
        .out_ready        (rsp.ready),
        .out_status       (rsp.status),
        .out_chain_head   (rsp.chain_head),
        .out_link_value   (rsp.link_value),
        .out_blocks_taken (rsp.blocks_taken)
    );

    // one word at a time: an accept closes the request side
    assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> !req.ready)
        else $error("request accepted while a word is in progress");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.chain_head == fca_pkg::LINK_END |-> rsp.blocks_taken == 5'd0)
        else $error("blocks counted with no chain head");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.link_value != fca_pkg::LINK_FREE
            |-> rsp.status == fca_pkg::STATUS_OK)
        else $error("link reported on a failed read");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.status == fca_pkg::STATUS_NO_SPACE |-> rsp.link_value == 16'd0)
        else $error("no-space response carries a link");

endmodule

@@ tb/tb_fat_chain_allocator_top.sv @@
// Self-checking testbench for the chain allocator: directed rows, then random chain traffic.
module tb_fat_chain_allocator_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          PROBES      = 25;
    localparam int          PHASES      = 8;
    localparam int unsigned CYCLE_LIMIT = 600000;
    localparam int          HEADS_MAX   = 12;

    typedef struct packed {
        fca_pkg::status_t status;
        logic [15:0]      chain_head;
        logic [15:0]      link_value;
        logic [4:0]       blocks_taken;
    } reply_t;

    typedef struct packed {
        fca_pkg::kind_t kind;
        logic [15:0]    blk;
        logic [15:0]    len;
        logic           fixed;
        reply_t         want;
    } probe_t;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [4:0] cfg_wdata;

    fca_in_if  req ();
    fca_out_if rsp ();

    fat_chain_allocator_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req),
        .rsp       (rsp)
    );

    // shadow copy of the link table and the data floor register
    logic [15:0] fat_q [fca_pkg::NUM_BLOCKS];
    logic [4:0]  floor_q;

    reply_t      replies_due [$];
    logic [15:0] live_heads [$];
    reply_t      due;
    int          faults = 0;
    int unsigned cycles = 0;
    logic        calm = 1'b0;

    // fixed rows start from the reset table: 0..2 end, floor 3
    probe_t probe_rows [PROBES] = '{
        '{fca_pkg::KIND_NEXT,    16'd0,     16'd0,     1'b1,
          '{fca_pkg::STATUS_OK, fca_pkg::LINK_END, fca_pkg::LINK_END, 5'd0}},
        '{fca_pkg::KIND_NEXT,    16'd19,    16'hFFFF,  1'b1,
          '{fca_pkg::STATUS_OK, fca_pkg::LINK_END, fca_pkg::LINK_FREE, 5'd0}},
        '{fca_pkg::KIND_NEXT,    16'd20,    16'd0,     1'b1,
          '{fca_pkg::STATUS_RANGE, fca_pkg::LINK_END, fca_pkg::LINK_FREE, 5'd0}},
        '{fca_pkg::KIND_NEXT,    16'hFFFF,  16'd0,     1'b1,
          '{fca_pkg::STATUS_RANGE, fca_pkg::LINK_END, fca_pkg::LINK_FREE, 5'd0}},
        '{fca_pkg::KIND_FREE,    16'hFFFF,  16'd0,     1'b1,
          '{fca_pkg::STATUS_OK, fca_pkg::LINK_END, fca_pkg::LINK_FREE, 5'd0}},
        '{fca_pkg::KIND_FREE,    16'd20,    16'd0,     1'b1,
          '{fca_pkg::STATUS_RANGE, fca_pkg::LINK_END, fca_pkg::LINK_FREE, 5'd0}},
        '{fca_pkg::KIND_FREE,    16'd0,     16'd0,     1'b1,
          '{fca_pkg::STATUS_OK, fca_pkg::LINK_END, fca_pkg::LINK_FREE, 5'd0}},
        '{fca_pkg::KIND_REWRITE, 16'hFFFF,  16'd0,     1'b1,
          '{fca_pkg::STATUS_OK, fca_pkg::LINK_END, fca_pkg::LINK_FREE, 5'd0}},
        '{fca_pkg::KIND_REWRITE, 16'hFFFF,  16'd1,     1'b1,
          '{fca_pkg::STATUS_OK, 16'd3, fca_pkg::LINK_FREE, 5'd1}},
        '{fca_pkg::KIND_REWRITE, 16'hFFFF,  16'd128,   1'b1,
          '{fca_pkg::STATUS_OK, 16'd4, fca_pkg::LINK_FREE, 5'd1}},
        '{fca_pkg::KIND_REWRITE, 16'hFFFF,  16'd129,   1'b1,
          '{fca_pkg::STATUS_OK, 16'd5, fca_pkg::LINK_FREE, 5'd2}},
        '{fca_pkg::KIND_NEXT,    16'd5,     16'd0,     1'b1,
          '{fca_pkg::STATUS_OK, fca_pkg::LINK_END, 16'd6, 5'd0}},
        '{fca_pkg::KIND_NEXT,    16'd6,     16'd0,     1'b1,
          '{fca_pkg::STATUS_OK, fca_pkg::LINK_END, fca_pkg::LINK_END, 5'd0}},
        '{fca_pkg::KIND_REWRITE, 16'd5,     16'd256,   1'b0, '0},
        '{fca_pkg::KIND_FREE,    16'd3,     16'd0,     1'b0, '0},
        // old block out of range, then run out of space part way
        '{fca_pkg::KIND_REWRITE, 16'h9C40,  16'hFFFF,  1'b0, '0},
        '{fca_pkg::KIND_NEXT,    16'd19,    16'd0,     1'b0, '0},
        '{fca_pkg::KIND_REWRITE, 16'hFFFF,  16'd1,     1'b1,
          '{fca_pkg::STATUS_NO_SPACE, fca_pkg::LINK_END, fca_pkg::LINK_FREE, 5'd0}},
        '{fca_pkg::KIND_FREE,    16'd3,     16'd0,     1'b0, '0},
        '{fca_pkg::KIND_FREE,    16'd4,     16'd0,     1'b0, '0},
        '{fca_pkg::KIND_NEXT,    16'hAAAA,  16'd0,     1'b1,
          '{fca_pkg::STATUS_RANGE, fca_pkg::LINK_END, fca_pkg::LINK_FREE, 5'd0}},
        '{fca_pkg::KIND_FREE,    16'h5555,  16'd0,     1'b1,
          '{fca_pkg::STATUS_RANGE, fca_pkg::LINK_END, fca_pkg::LINK_FREE, 5'd0}},
        '{fca_pkg::KIND_FORMAT,  16'h5555,  16'hAAAA,  1'b1,
          '{fca_pkg::STATUS_OK, fca_pkg::LINK_END, fca_pkg::LINK_FREE, 5'd0}},
        '{fca_pkg::KIND_NEXT,    16'd2,     16'd0,     1'b1,
          '{fca_pkg::STATUS_OK, fca_pkg::LINK_END, fca_pkg::LINK_END, 5'd0}},
        '{fca_pkg::KIND_NEXT,    16'd3,     16'd0,     1'b1,
          '{fca_pkg::STATUS_OK, fca_pkg::LINK_END, fca_pkg::LINK_FREE, 5'd0}}
    };

    logic [4:0] phase_floor [PHASES] = '{5'd0, 5'd20, 5'd5, 5'd31, 5'd21, 5'd1, 5'd12, 5'd3};
    int         phase_items [PHASES] = '{160, 110, 200, 90, 90, 160, 160, 160};

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic int floor_idx();
        return (int'(floor_q) > fca_pkg::NUM_BLOCKS) ? fca_pkg::NUM_BLOCKS : int'(floor_q);
    endfunction

    function automatic int take_block();
        for (int i = floor_idx(); i < fca_pkg::NUM_BLOCKS; i++)
        begin
            if (fat_q[i] == fca_pkg::LINK_FREE)
            begin
                fat_q[i] = fca_pkg::LINK_END;
                return i;
            end
        end
        return -1;
    endfunction

    // walk stops out of range, on a free entry, after an end entry, or after a table's worth
    function automatic void release_chain(logic [15:0] start);
        logic [15:0] cur;
        logic [15:0] nxt;
        cur = start;
        for (int s = 0; s < fca_pkg::NUM_BLOCKS; s++)
        begin
            if (cur == fca_pkg::LINK_END || cur == fca_pkg::LINK_FREE ||
                cur >= fca_pkg::NUM_BLOCKS)
                break;
            nxt = fat_q[cur];
            fat_q[cur] = fca_pkg::LINK_FREE;
            if (nxt == fca_pkg::LINK_END)
                break;
            cur = nxt;
        end
    endfunction

    function automatic reply_t chain_step(fca_pkg::kind_t k, logic [15:0] blk,
                                          logic [15:0] len);
        reply_t r;
        int     need;
        int     prev;
        int     b;
        int     cnt;
        r.status       = fca_pkg::STATUS_OK;
        r.chain_head   = fca_pkg::LINK_END;
        r.link_value   = fca_pkg::LINK_FREE;
        r.blocks_taken = '0;
        case (k)
            fca_pkg::KIND_REWRITE:
            begin
                need = (int'(len) + fca_pkg::BLOCK_BYTES - 1) / fca_pkg::BLOCK_BYTES;
                prev = -1;
                cnt  = 0;
                if (blk != fca_pkg::LINK_END)
                    release_chain(blk);
                while (cnt < need)
                begin
                    b = take_block();
                    if (b < 0)
                    begin
                        // keep the partial chain
                        r.status = fca_pkg::STATUS_NO_SPACE;
                        break;
                    end
                    if (prev < 0)
                        r.chain_head = 16'(b);
                    else
                        fat_q[prev] = 16'(b);
                    prev = b;
                    cnt++;
                end
                r.blocks_taken = 5'(cnt);
            end
            fca_pkg::KIND_FREE:
            begin
                if (blk != fca_pkg::LINK_END && blk >= fca_pkg::NUM_BLOCKS)
                    r.status = fca_pkg::STATUS_RANGE;
                else
                    release_chain(blk);
            end
            fca_pkg::KIND_NEXT:
            begin
                if (blk >= fca_pkg::NUM_BLOCKS)
                    r.status = fca_pkg::STATUS_RANGE;
                else
                    r.link_value = fat_q[blk];
            end
            default:
            begin
                for (int i = 0; i < fca_pkg::NUM_BLOCKS; i++)
                    fat_q[i] = (i < floor_idx()) ? fca_pkg::LINK_END : fca_pkg::LINK_FREE;
            end
        endcase
        return r;
    endfunction

    task automatic send_op(fca_pkg::kind_t k, logic [15:0] blk, logic [15:0] len,
                           logic fixed, reply_t want);
        reply_t got;
        while (!calm && $urandom_range(99) < 32)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid       <= 1'b1;
        req.kind        <= k;
        req.block       <= blk;
        req.byte_length <= len;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        got = chain_step(k, blk, len);
        replies_due.push_back(fixed ? want : got);
        if (k == fca_pkg::KIND_FORMAT)
            live_heads.delete();
        else if (k == fca_pkg::KIND_REWRITE && got.chain_head != fca_pkg::LINK_END)
        begin
            live_heads.push_back(got.chain_head);
            if (live_heads.size() > HEADS_MAX)
                void'(live_heads.pop_front());
        end
    endtask

    // drop valid and hold until every outstanding word has come back
    task automatic drain();
        req.valid <= 1'b0;
        while (replies_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_floor(logic [4:0] v);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we  <= 1'b0;
        floor_q = v;
    endtask

    function automatic logic [15:0] grab_head();
        int idx;
        logic [15:0] h;
        idx = $urandom_range(live_heads.size() - 1);
        h = live_heads[idx];
        live_heads.delete(idx);
        return h;
    endfunction

    task automatic random_op();
        int             pick;
        fca_pkg::kind_t k;
        logic [15:0]    blk;
        logic [15:0]    len;
        pick = $urandom_range(99);
        len  = '0;
        if (pick < 38)
        begin
            k = fca_pkg::KIND_REWRITE;
            if (live_heads.size() != 0 && $urandom_range(99) < 60)
                blk = grab_head();
            else if ($urandom_range(99) < 70)
                blk = fca_pkg::LINK_END;
            else
                blk = 16'($urandom_range(fca_pkg::NUM_BLOCKS - 1));
            len = ($urandom_range(99) < 85) ? 16'($urandom_range(5 * fca_pkg::BLOCK_BYTES))
                                            : 16'($urandom);
        end
        else if (pick < 55)
        begin
            k = fca_pkg::KIND_FREE;
            if (live_heads.size() != 0 && $urandom_range(99) < 75)
                blk = grab_head();
            else
                blk = 16'($urandom_range(fca_pkg::NUM_BLOCKS - 1));
        end
        else if (pick < 80)
        begin
            k   = fca_pkg::KIND_NEXT;
            blk = 16'($urandom_range(fca_pkg::NUM_BLOCKS - 1));
        end
        else if (pick < 83)
        begin
            k   = fca_pkg::KIND_FORMAT;
            blk = 16'($urandom);
        end
        else
        begin
            k   = fca_pkg::kind_t'($urandom_range(3));
            blk = 16'($urandom);
            len = 16'($urandom);
        end
        send_op(k, blk, len, 1'b0, '0);
    endtask

    // response side: check accepted words, then pick next cycle's ready
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            rsp.ready <= 1'b0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (replies_due.size() == 0)
                begin
                    $error("response word with nothing expected");
                    faults++;
                end
                else
                begin
                    due = replies_due.pop_front();
                    if (rsp.status !== due.status)
                    begin
                        $error("status mismatch: expected %0d, got %0d", due.status, rsp.status);
                        faults++;
                    end
                    if (rsp.chain_head !== due.chain_head)
                    begin
                        $error("chain_head mismatch: expected %0d, got %0d",
                               due.chain_head, rsp.chain_head);
                        faults++;
                    end
                    if (rsp.link_value !== due.link_value)
                    begin
                        $error("link_value mismatch: expected %0d, got %0d",
                               due.link_value, rsp.link_value);
                        faults++;
                    end
                    if (rsp.blocks_taken !== due.blocks_taken)
                    begin
                        $error("blocks_taken mismatch: expected %0d, got %0d",
                               due.blocks_taken, rsp.blocks_taken);
                        faults++;
                    end
                end
            end
            rsp.ready <= calm || ($urandom_range(99) >= 32);
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_fat_chain_allocator_top NOT OK");
            $finish;
        end
    end

    initial
    begin
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_wdata       = '0;
        req.valid       = 1'b0;
        req.kind        = fca_pkg::KIND_NEXT;
        req.block       = '0;
        req.byte_length = '0;
        floor_q         = 5'(fca_pkg::FDB_RESET);
        for (int i = 0; i < fca_pkg::NUM_BLOCKS; i++)
            fat_q[i] = (i < fca_pkg::FDB_RESET) ? fca_pkg::LINK_END : fca_pkg::LINK_FREE;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < PROBES; i++)
            send_op(probe_rows[i].kind, probe_rows[i].blk, probe_rows[i].len,
                    probe_rows[i].fixed, probe_rows[i].want);

        for (int p = 0; p < PHASES; p++)
        begin
            set_floor(phase_floor[p]);
            // one phase runs with no idling on either side
            calm <= (p == 2);
            send_op(fca_pkg::KIND_FORMAT, 16'd0, 16'd0, 1'b0, '0);
            for (int n = 0; n < phase_items[p]; n++)
            begin
                if (n == 60)
                    drain();
                random_op();
            end
        end

        drain();
        repeat (40) @(posedge clk);
        if (faults == 0)
            $display("tb_fat_chain_allocator_top OK");
        else
            $display("tb_fat_chain_allocator_top NOT OK");
        $finish;
    end

endmodule
